### rtl/tcpq_pkg.sv
// Shared types and constants for the two-class priority queue.
// Used by tcpq_cell, two_class_priority_queue_core and tcpq_checker; no dependencies.
`default_nettype none

package tcpq_pkg;

  localparam int unsigned DEPTH           = 16;
  localparam int unsigned AGE_W           = 8;
  localparam int unsigned OCC_W           = 5;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd59;

  typedef enum logic [1:0] {
    CmdJoin     = 2'd0,
    CmdPriority = 2'd1,
    CmdLeave    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e             command;
    logic [AGE_W-1:0] age;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [AGE_W-1:0] removed_age;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic             ins;     // insert request accepted
    logic             pri;     // insert goes behind the leading priority run
    logic             leave;   // head removal accepted
    logic [AGE_W-1:0] age;
    logic [AGE_W-1:0] thr;
  } ctrl_t;

endpackage

`default_nettype wire

### rtl/two_class_priority_queue_core.sv
// Top level of the two-class priority queue: a row of tcpq_cell slots plus count,
// threshold register and result register. Depends on tcpq_pkg and tcpq_cell.
//
// Takes one command per clock: busy never rises, and the result appears on
// rsp_o with done_o for exactly one cycle, the cycle after the edge that accepts
// start. Results cannot be held off. The cost of a command is the ripple of the
// priority-run flag through the DEPTH cells, all combinational; every cell then
// loads, holds or shifts from a neighbor in parallel. Queue slots are not cleared
// at reset; only the entry count, the threshold and the done flag are.
`default_nettype none

module two_class_priority_queue_core #(
  parameter int unsigned DEPTH = tcpq_pkg::DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire tcpq_pkg::req_t                req_i,
  output logic                               done_o,
  output tcpq_pkg::rsp_t                     rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tcpq_pkg::AGE_W-1:0]    cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]               count_q, count_d;
  logic [tcpq_pkg::AGE_W-1:0]     thr_q;
  logic                           done_q;
  tcpq_pkg::rsp_t                 rsp_q, rsp_d;
  tcpq_pkg::ctrl_t                ctrl;
  logic                           accept, full, empty;
  logic [CNT_W+tcpq_pkg::OCC_W-1:0] cnt_ext;

  logic [DEPTH:0]                 run;
  logic [DEPTH-1:0]               ahead;
  logic [DEPTH-1:0]               left_ahead;
  logic [tcpq_pkg::AGE_W-1:0]     data       [DEPTH];
  logic [tcpq_pkg::AGE_W-1:0]     left_data  [DEPTH];
  logic [tcpq_pkg::AGE_W-1:0]     right_data [DEPTH];

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign full   = count_q == CNT_W'(DEPTH);
  assign empty  = count_q == '0;

  always_comb begin
    ctrl        = '0;
    ctrl.age    = req_i.age;
    ctrl.thr    = thr_q;
    ctrl.pri    = (req_i.command == tcpq_pkg::CmdPriority) && (req_i.age > thr_q);
    count_d     = count_q;
    rsp_d       = '0;
    rsp_d.status = tcpq_pkg::StDone;
    case (req_i.command)
      tcpq_pkg::CmdJoin, tcpq_pkg::CmdPriority: begin
        if (full) begin
          rsp_d.status = tcpq_pkg::StFull;
        end else begin
          ctrl.ins = accept;
          count_d  = count_q + CNT_W'(1);
        end
      end
      tcpq_pkg::CmdLeave: begin
        if (empty) begin
          rsp_d.status = tcpq_pkg::StEmpty;
        end else begin
          ctrl.leave        = accept;
          rsp_d.removed_age = data[0];
          count_d           = count_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
    cnt_ext         = {{tcpq_pkg::OCC_W{1'b0}}, count_d};
    rsp_d.occupancy = cnt_ext[tcpq_pkg::OCC_W-1:0];
  end

  assign run[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_ahead[i] = 1'b1;
      assign left_data[i]  = req_i.age;
    end else begin : g_body
      assign left_ahead[i] = ahead[i-1];
      assign left_data[i]  = data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_data[i] = data[i];
    end else begin : g_inner
      assign right_data[i] = data[i+1];
    end

    tcpq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .run_i         (run[i]),
      .left_ahead_i  (left_ahead[i]),
      .left_data_i   (left_data[i]),
      .right_data_i  (right_data[i]),
      .run_o         (run[i+1]),
      .ahead_o       (ahead[i]),
      .data_o        (data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      thr_q   <= tcpq_pkg::THRESHOLD_RESET;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

### rtl/tcpq_cell.sv
// One queue slot: holds an age and shifts with its neighbors on insert/leave.
// Depends on tcpq_pkg.
`default_nettype none

module tcpq_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  wire logic                           clk_i,
  input  wire tcpq_pkg::ctrl_t                ctrl_i,
  input  wire logic [CNT_W-1:0]               count_i,
  input  wire logic                           run_i,
  input  wire logic                           left_ahead_i,
  input  wire logic [tcpq_pkg::AGE_W-1:0]     left_data_i,
  input  wire logic [tcpq_pkg::AGE_W-1:0]     right_data_i,
  output logic                                run_o,
  output logic                                ahead_o,
  output logic [tcpq_pkg::AGE_W-1:0]          data_o
);

  logic [tcpq_pkg::AGE_W-1:0] data_q, data_d;
  logic                       valid;

  assign valid = count_i > CNT_W'(INDEX);
  // run stays high through the leading stretch of priority entries
  assign run_o    = run_i & valid & (data_q > ctrl_i.thr);
  // slot sits ahead of the insert point
  assign ahead_o  = ctrl_i.pri ? run_o : valid;
  assign data_o   = data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (!ahead_o) begin
        data_d = left_ahead_i ? ctrl_i.age : left_data_i;
      end
    end else if (ctrl_i.leave) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

`default_nettype wire

### rtl/tcpq_checker.sv
// Port-level checks for two_class_priority_queue_core, bound to the top level.
// Depends on tcpq_pkg.
`default_nettype none

module tcpq_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            done_o,
  input wire tcpq_pkg::rsp_t  rsp_o
);

  // every accepted request produces exactly one result, in the cycle after it
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without request");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != tcpq_pkg::StDone) |-> rsp_o.removed_age == '0)
    else $error("refused request returned an age");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == tcpq_pkg::StEmpty) |-> rsp_o.occupancy == '0)
    else $error("empty refusal with nonzero occupancy");

  // back-to-back results move occupancy by at most one
  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o)) |->
      (rsp_o.occupancy == $past(rsp_o.occupancy)) ||
      (rsp_o.occupancy == tcpq_pkg::OCC_W'($past(rsp_o.occupancy) + 1)) ||
      (rsp_o.occupancy == tcpq_pkg::OCC_W'($past(rsp_o.occupancy) - 1)))
    else $error("occupancy jumped");

endmodule

bind two_class_priority_queue_core tcpq_checker u_tcpq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire
